[hdl/ftwp_pkg.sv]
package ftwp_pkg;

    localparam int NUM_W   = 85;              // widest dividend: 64-bit ticks times 1e6, rounded
    localparam int CNT_W   = 7;               // divider step counter
    localparam int MUL_W   = 20;              // bits of the microsecond scale factor

    localparam logic [MUL_W-1:0] US_PER_SECOND  = 20'd1000000;
    localparam logic [32:0]      FPS_TENTHS_NUM = 33'd10000000;
    localparam logic [31:0]      TENTHS_DIV     = 32'd100;
    localparam logic [32:0]      TENTHS_HALF    = 33'd50;

    localparam logic [31:0] TICK_RATE_RESET  = 32'd1000000;
    localparam logic [31:0] WINDOW_LEN_RESET = 32'd500000;

    localparam logic [CNT_W-1:0] ITERS_CONV  = 7'd85;
    localparam logic [CNT_W-1:0] ITERS_AVG   = 7'd65;
    localparam logic [CNT_W-1:0] ITERS_SCALE = 7'd33;

    localparam logic [0:0] REG_TICK_RATE  = 1'b0;
    localparam logic [0:0] REG_WINDOW_LEN = 1'b1;

    localparam logic [2:0] ACT_FRAME_BEGIN = 3'd0;
    localparam logic [2:0] ACT_DRAW_BEGIN  = 3'd1;
    localparam logic [2:0] ACT_DRAW_END    = 3'd2;
    localparam logic [2:0] ACT_FRAME_END   = 3'd3;
    localparam logic [2:0] ACT_WIN_RESET   = 3'd4;

    typedef struct packed {
        logic             go;
        logic [CNT_W-1:0] iters;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

[hdl/ftwp_div.sv]
module ftwp_div import ftwp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  div_req_t          req,
    input  logic [NUM_W-1:0]  num,     // dividend, left-aligned
    input  logic [31:0]       den,
    output div_sts_t          sts,
    output logic [NUM_W-1:0]  quot
);

    logic [NUM_W-1:0] num_reg, num_next;
    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [32:0]      rem_reg, rem_next;
    logic [31:0]      den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [32:0]      rem_try;

    assign rem_try = {rem_reg[31:0], num_reg[NUM_W-1]};

    always_comb begin
        num_next  = num_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.go) begin
            num_next  = num;
            den_next  = den;
            quot_next = '0;
            rem_next  = '0;
            cnt_next  = req.iters;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // one quotient bit per cycle, restoring
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            if (rem_try >= {1'b0, den_reg}) begin
                rem_next  = rem_try - {1'b0, den_reg};
                quot_next = {quot_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_try;
                quot_next = {quot_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        cnt_reg  <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quot     = quot_reg;

endmodule

[hdl/frame_time_window_profiler_top.sv]
// Channel   | Direction | Transfer contents
// s_ (in)   | input     | tuser[2:0] action, tdata[63:0] timestamp
// m_ (out)  | output    | tdata: fps_tenths, rest_ms_tenths, draw_ms_tenths
// cfg       | input     | index 0 tick_rate_hz, index 1 window_length_us
//
// A frame end runs two tick-to-microsecond conversions (20 multiply steps
// plus 85 divide steps each); a closing window adds three 65-step and three
// 33-step divisions, all on the one shared bit-serial divider. Reset is
// synchronous and clears all tracking and the window. A result waiting on
// m_tready holds in the output register while the next event is taken; the
// input stalls while a frame end or window close is processed and while a
// result is still pending for the output register.
module frame_time_window_profiler_top import ftwp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [63:0] timestamp
    input  logic [2:0]  s_tuser,    // [2:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,    // [23:0] fps_tenths, [49:24] rest_ms_tenths,
                                    // [75:50] draw_ms_tenths, [79:76] zero
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_CDIV = 7'b0000100,
        S_ACC  = 7'b0001000,
        S_CHK  = 7'b0010000,
        S_ADIV = 7'b0100000,
        S_SDIV = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    logic        emit_reg, emit_next;   // result pending for the output register

    logic [31:0] rate_reg, len_reg;
    logic [63:0] fs_reg, fs_next, ds_reg, ds_next, fdt_reg, fdt_next;
    logic        fo_reg, fo_next, do_reg, do_next;
    logic [63:0] tot_reg, tot_next, rsum_reg, rsum_next, dsum_reg, dsum_next;
    logic [31:0] cnt_reg, cnt_next;

    logic [63:0] dt_reg, dt_next;    // draw ticks
    logic [63:0] rus_reg, rus_next, dus_reg, dus_next;
    logic [63:0] mcand_reg, mcand_next;
    logic [83:0] acc_reg, acc_next, acc_step;
    logic [4:0]  mcnt_reg, mcnt_next;
    logic        csel_reg, csel_next;
    logic [1:0]  sel_reg, sel_next;
    logic [31:0] avg0_reg, avg0_next, avg1_reg, avg1_next, avg2_reg, avg2_next;

    logic [23:0] rf_reg, rf_next;
    logic [25:0] rr_reg, rr_next, rd_reg, rd_next;
    logic        mv_reg, mv_next;
    logic [79:0] md_reg, md_next;

    div_req_t         dreq;
    div_sts_t         dsts;
    logic [NUM_W-1:0] dnum, dquot;
    logic [31:0]      dden;

    logic [63:0] t_in, draw_tot, span_ticks, conv_us, sum_sel;
    logic [64:0] fus_w, tot_w, rs_w, ds_w;
    logic [63:0] whole_us;
    logic [31:0] avg_sat;
    logic [64:0] avg_num;
    logic [32:0] sc_num;
    logic        out_free, s_acc;

    ftwp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .num     (dnum),
        .den     (dden),
        .sts     (dsts),
        .quot    (dquot)
    );

    assign t_in     = s_tdata;
    assign s_tready = (state_reg == S_IDLE) && !emit_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !mv_reg || m_tready;

    assign draw_tot    = fdt_reg + (do_reg ? (t_in - ds_reg) : 64'd0);
    assign span_ticks  = t_in - fs_reg;
    assign acc_step    = {acc_reg[82:0], 1'b0}
                         + (US_PER_SECOND[mcnt_reg] ? {20'd0, mcand_reg} : 84'd0);
    assign conv_us     = (|dquot[NUM_W-1:64]) ? {64{1'b1}} : dquot[63:0];
    assign avg_sat     = (|dquot[NUM_W-1:32]) ? {32{1'b1}} : dquot[31:0];

    assign fus_w    = {1'b0, rus_reg} + {1'b0, dus_reg};
    assign whole_us = fus_w[64] ? {64{1'b1}} : fus_w[63:0];
    assign tot_w    = {1'b0, tot_reg} + {1'b0, whole_us};
    assign rs_w     = {1'b0, rsum_reg} + {1'b0, rus_reg};
    assign ds_w     = {1'b0, dsum_reg} + {1'b0, dus_reg};

    always_comb begin
        case (sel_reg)
            2'd0:    sum_sel = tot_reg;
            2'd1:    sum_sel = rsum_reg;
            default: sum_sel = dsum_reg;
        endcase
    end
    assign avg_num = {1'b0, sum_sel} + {34'd0, cnt_reg[31:1]};

    always_comb begin
        state_next = state_reg;
        emit_next  = emit_reg;
        fs_next = fs_reg;  ds_next = ds_reg;  fdt_next = fdt_reg;
        fo_next = fo_reg;  do_next = do_reg;
        tot_next = tot_reg;  rsum_next = rsum_reg;  dsum_next = dsum_reg;
        cnt_next = cnt_reg;
        dt_next = dt_reg;  rus_next = rus_reg;  dus_next = dus_reg;
        mcand_next = mcand_reg;  acc_next = acc_reg;  mcnt_next = mcnt_reg;
        csel_next = csel_reg;  sel_next = sel_reg;
        avg0_next = avg0_reg;  avg1_next = avg1_reg;  avg2_next = avg2_reg;
        rf_next = rf_reg;  rr_next = rr_reg;  rd_next = rd_reg;
        mv_next = mv_reg && !m_tready;
        md_next = md_reg;
        dreq.go    = 1'b0;
        dreq.iters = ITERS_CONV;
        dnum = '0;
        dden = rate_reg;
        sc_num = '0;

        // hand a finished result to the output register once it is free
        if (emit_reg && out_free) begin
            mv_next   = 1'b1;
            md_next   = {4'd0, rd_reg, rr_reg, rf_reg};
            emit_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    case (s_tuser)
                        ACT_FRAME_BEGIN: begin
                            fs_next = t_in;  ds_next = '0;  fdt_next = '0;
                            fo_next = 1'b1;  do_next = 1'b0;
                        end
                        ACT_DRAW_BEGIN: begin
                            if (!fo_reg) begin
                                fs_next = t_in;  fdt_next = '0;  fo_next = 1'b1;
                            end
                            ds_next = t_in;
                            do_next = 1'b1;
                        end
                        ACT_DRAW_END: begin
                            if (do_reg) begin
                                fdt_next = draw_tot;
                                do_next  = 1'b0;
                            end
                        end
                        ACT_FRAME_END: begin
                            if (fo_reg) begin
                                fdt_next = draw_tot;
                                do_next  = 1'b0;
                                fo_next  = 1'b0;
                                dt_next  = draw_tot;
                                if (rate_reg != 32'd0 &&
                                    (span_ticks > draw_tot || draw_tot != 64'd0)) begin
                                    mcand_next = (span_ticks > draw_tot) ?
                                                 span_ticks - draw_tot : 64'd0;
                                    acc_next   = '0;
                                    mcnt_next  = 5'(MUL_W - 1);
                                    csel_next  = 1'b0;
                                    state_next = S_MUL;
                                end
                            end
                        end
                        ACT_WIN_RESET: begin
                            tot_next = '0;  rsum_next = '0;  dsum_next = '0;  cnt_next = '0;
                            rf_next = '0;  rr_next = '0;  rd_next = '0;
                            emit_next = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL: begin
                acc_next  = acc_step;
                mcnt_next = mcnt_reg - 1'b1;
                if (mcnt_reg == 5'd0) begin
                    dreq.go    = 1'b1;
                    dreq.iters = ITERS_CONV;
                    dnum       = {1'b0, acc_step} + {53'd0, 1'b0, rate_reg[31:1]};
                    dden       = rate_reg;
                    state_next = S_CDIV;
                end
            end
            S_CDIV: begin
                if (dsts.done) begin
                    if (!csel_reg) begin
                        rus_next   = conv_us;
                        csel_next  = 1'b1;
                        mcand_next = dt_reg;
                        acc_next   = '0;
                        mcnt_next  = 5'(MUL_W - 1);
                        state_next = S_MUL;
                    end else begin
                        dus_next   = conv_us;
                        state_next = S_ACC;
                    end
                end
            end
            S_ACC: begin
                if (whole_us == 64'd0) begin
                    state_next = S_IDLE;
                end else begin
                    tot_next  = tot_w[64] ? {64{1'b1}} : tot_w[63:0];
                    rsum_next = rs_w[64] ? {64{1'b1}} : rs_w[63:0];
                    dsum_next = ds_w[64] ? {64{1'b1}} : ds_w[63:0];
                    if (cnt_reg != {32{1'b1}})
                        cnt_next = cnt_reg + 1'b1;
                    sel_next   = 2'd0;
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                if (tot_reg < {32'd0, len_reg}) begin
                    state_next = S_IDLE;
                end else begin
                    dreq.go    = 1'b1;
                    dreq.iters = ITERS_AVG;
                    dnum       = {avg_num, 20'd0};
                    dden       = cnt_reg;
                    state_next = S_ADIV;
                end
            end
            S_ADIV: begin
                dden = cnt_reg;
                if (dsts.done) begin
                    case (sel_reg)
                        2'd0:    avg0_next = avg_sat;
                        2'd1:    avg1_next = avg_sat;
                        default: avg2_next = avg_sat;
                    endcase
                    if (sel_reg != 2'd2) begin
                        sel_next   = sel_reg + 1'b1;
                        state_next = S_CHK;
                    end else begin
                        sel_next = 2'd0;
                        if (avg0_reg == 32'd0) begin
                            // zero average frame time: all-zero result
                            rf_next = '0;  rr_next = '0;  rd_next = '0;
                            tot_next = '0;  rsum_next = '0;  dsum_next = '0;
                            cnt_next = '0;
                            emit_next  = 1'b1;
                            state_next = S_IDLE;
                        end else begin
                            dreq.go    = 1'b1;
                            dreq.iters = ITERS_SCALE;
                            sc_num     = FPS_TENTHS_NUM + {2'd0, avg0_reg[31:1]};
                            dnum       = {sc_num, 52'd0};
                            dden       = avg0_reg;
                            state_next = S_SDIV;
                        end
                    end
                end
            end
            S_SDIV: begin
                if (dsts.done) begin
                    case (sel_reg)
                        2'd0:    rf_next = dquot[23:0];
                        2'd1:    rr_next = dquot[25:0];
                        default: rd_next = dquot[25:0];
                    endcase
                    if (sel_reg != 2'd2) begin
                        sel_next   = sel_reg + 1'b1;
                        dreq.go    = 1'b1;
                        dreq.iters = ITERS_SCALE;
                        sc_num     = (sel_reg == 2'd0) ? {1'b0, avg1_reg} + TENTHS_HALF
                                                       : {1'b0, avg2_reg} + TENTHS_HALF;
                        dnum       = {sc_num, 52'd0};
                        dden       = TENTHS_DIV;
                    end else begin
                        tot_next = '0;  rsum_next = '0;  dsum_next = '0;  cnt_next = '0;
                        emit_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        dt_reg <= dt_next;  rus_reg <= rus_next;  dus_reg <= dus_next;
        mcand_reg <= mcand_next;  acc_reg <= acc_next;  mcnt_reg <= mcnt_next;
        csel_reg <= csel_next;  sel_reg <= sel_next;
        avg0_reg <= avg0_next;  avg1_reg <= avg1_next;  avg2_reg <= avg2_next;
        rf_reg <= rf_next;  rr_reg <= rr_next;  rd_reg <= rd_next;
        md_reg <= md_next;
        if (!aresetn) begin
            state_reg <= S_IDLE;
            emit_reg  <= 1'b0;
            mv_reg    <= 1'b0;
            rate_reg  <= TICK_RATE_RESET;
            len_reg   <= WINDOW_LEN_RESET;
            fs_reg <= '0;  ds_reg <= '0;  fdt_reg <= '0;
            fo_reg <= 1'b0;  do_reg <= 1'b0;
            tot_reg <= '0;  rsum_reg <= '0;  dsum_reg <= '0;  cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            emit_reg  <= emit_next;
            mv_reg    <= mv_next;
            if (cfg_we && cfg_index == REG_TICK_RATE)  rate_reg <= cfg_wdata;
            if (cfg_we && cfg_index == REG_WINDOW_LEN) len_reg  <= cfg_wdata;
            fs_reg <= fs_next;  ds_reg <= ds_next;  fdt_reg <= fdt_next;
            fo_reg <= fo_next;  do_reg <= do_next;
            tot_reg <= tot_next;  rsum_reg <= rsum_next;  dsum_reg <= dsum_next;
            cnt_reg <= cnt_next;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

    a_done_in_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        dsts.done |-> (state_reg == S_CDIV || state_reg == S_ADIV || state_reg == S_SDIV))
        else $error("divider finished outside a division step");

    a_empty_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 32'd0) |-> (tot_reg == 64'd0))
        else $error("window total without counted frames");

    a_draw_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        !fo_reg |-> !do_reg)
        else $error("draw open outside a frame");

    a_no_lost_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_reg && mv_reg && !m_tready) |=> emit_reg)
        else $error("pending result dropped");

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;
    import ftwp_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES   = 1200;

    typedef struct packed {
        logic [2:0]  action;
        logic [63:0] stamp;
    } event_t;

    typedef struct packed {
        logic [25:0] draw;
        logic [25:0] rest;
        logic [23:0] fps;
    } stats_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    frame_time_window_profiler_top DUT (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    event_t pending_events[$];
    stats_t expected_stats[$];
    int     error_count = 0;
    int     idle_cycles = 0;

    // predictor state
    logic [31:0] p_rate, p_winlen;
    logic [63:0] p_fstart, p_dstart, p_fdraw, p_tot, p_rest, p_draw;
    logic        p_fopen, p_dopen;
    logic [31:0] p_count;

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [63:0] to_us(logic [63:0] ticks);
        logic [63:0]  q, r, f;
        logic [127:0] frac, full;
        f = {32'd0, p_rate};
        q = ticks / f;
        r = ticks % f;
        frac = ({64'd0, r} * 128'd1000000 + {65'd0, f[63:1]}) / {64'd0, f};
        full = {64'd0, q} * 128'd1000000 + frac;
        return (full[127:64] != 0) ? '1 : full[63:0];
    endfunction

    function automatic logic [31:0] avg_of(logic [63:0] sum, logic [31:0] cnt);
        logic [64:0] q, r, c;
        c = {33'd0, cnt};
        q = {1'b0, sum} / c;
        r = {1'b0, sum} % c;
        if (r + (c >> 1) >= c) q = q + 1;
        return (q > 65'hFFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
    endfunction

    task automatic predict_reset();
        p_rate = TICK_RATE_RESET; p_winlen = WINDOW_LEN_RESET;
        p_fstart = 0; p_dstart = 0; p_fdraw = 0; p_fopen = 0; p_dopen = 0;
        p_tot = 0; p_rest = 0; p_draw = 0; p_count = 0;
    endtask

    task automatic open_frame(logic [63:0] t);
        p_fstart = t; p_dstart = 0; p_fdraw = 0; p_fopen = 1; p_dopen = 0;
    endtask

    task automatic close_draw(logic [63:0] t);
        if (p_dopen) begin
            p_fdraw = p_fdraw + (t - p_dstart);
            p_dopen = 0;
        end
    endtask

    task automatic account(logic [63:0] rt, logic [63:0] dt);
        logic [63:0] rus, dus, fus;
        logic [31:0] af, ar, ad;
        stats_t s;
        if (p_rate == 0 || (rt == 0 && dt == 0)) return;
        rus = to_us(rt);
        dus = to_us(dt);
        fus = sat_add(rus, dus);
        if (fus == 0) return;
        p_tot = sat_add(p_tot, fus);
        p_rest = sat_add(p_rest, rus);
        p_draw = sat_add(p_draw, dus);
        if (p_count != 32'hFFFFFFFF) p_count++;
        if (p_tot < {32'd0, p_winlen}) return;
        af = avg_of(p_tot, p_count);
        ar = avg_of(p_rest, p_count);
        ad = avg_of(p_draw, p_count);
        s = '0;
        if (af > 0) begin
            s.fps  = 24'((64'd10000000 + {33'd0, af[31:1]}) / {32'd0, af});
            s.rest = 26'(({32'd0, ar} + 64'd50) / 64'd100);
            s.draw = 26'(({32'd0, ad} + 64'd50) / 64'd100);
        end
        expected_stats.push_back(s);
        p_tot = 0; p_rest = 0; p_draw = 0; p_count = 0;
    endtask

    task automatic predict_event(event_t e);
        logic [63:0] ft, rt;
        case (e.action)
            ACT_FRAME_BEGIN: open_frame(e.stamp);
            ACT_DRAW_BEGIN: begin
                if (!p_fopen) open_frame(e.stamp);
                p_dstart = e.stamp;
                p_dopen = 1;
            end
            ACT_DRAW_END: close_draw(e.stamp);
            ACT_FRAME_END: if (p_fopen) begin
                close_draw(e.stamp);
                ft = e.stamp - p_fstart;
                rt = (ft > p_fdraw) ? ft - p_fdraw : 0;
                p_fopen = 0;
                account(rt, p_fdraw);
            end
            ACT_WIN_RESET: begin
                p_tot = 0; p_rest = 0; p_draw = 0; p_count = 0;
                expected_stats.push_back('0);
            end
            default: ;
        endcase
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // driver
    int send_gap = 0;
    bit drive_on = 0;
    always @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            predict_event({s_tuser, s_tdata});
        end
        if (!s_tvalid || s_tready) begin
            if (send_gap > 0 || !drive_on || pending_events.size() == 0) begin
                if (send_gap > 0) send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else begin
                event_t e;
                e = pending_events.pop_front();
                s_tuser  <= e.action;
                s_tdata  <= e.stamp;
                s_tvalid <= 1'b1;
                send_gap <= gap_len();
            end
        end
    end

    // monitor
    int recv_gap = 0;
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            if (expected_stats.size() == 0) begin
                report("unexpected result", 32'(m_tdata[23:0]), 0);
            end else begin
                stats_t w, g;
                w = expected_stats.pop_front();
                g = m_tdata[75:0];
                if (g.fps != w.fps) report("fps_tenths", 32'(g.fps), 32'(w.fps));
                if (g.rest != w.rest) report("rest_ms_tenths", 32'(g.rest), 32'(w.rest));
                if (g.draw != w.draw) report("draw_ms_tenths", 32'(g.draw), 32'(w.draw));
                if (m_tdata[79:76] != 0) report("pad bits", 32'(m_tdata[79:76]), 0);
            end
        end
        if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) recv_gap <= gap_len();
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    logic [63:0] clock_now = 0;

    task automatic push_event(logic [2:0] a, logic [63:0] t);
        pending_events.push_back({a, t});
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] step_ticks();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r == 1) return rand64();
        if (r < 5) return $urandom_range(0, 3);
        return $urandom_range(1, 40000);
    endfunction

    task automatic push_frame();
        int k;
        push_event(ACT_FRAME_BEGIN, clock_now);
        clock_now += step_ticks();
        for (k = 0; k < $urandom_range(0, 2); k++) begin
            push_event(ACT_DRAW_BEGIN, clock_now);
            clock_now += step_ticks();
            if ($urandom_range(0, 3) != 0) push_event(ACT_DRAW_END, clock_now);
            clock_now += step_ticks();
        end
        push_event(ACT_FRAME_END, clock_now);
        clock_now += step_ticks();
    endtask

    task automatic push_noise();
        logic [2:0] a;
        a = 3'($urandom_range(0, 7));
        if (a == ACT_WIN_RESET && $urandom_range(0, 3) != 0) a = ACT_FRAME_END;
        push_event(a, ($urandom_range(0, 1) != 0) ? rand64() : clock_now);
        clock_now += step_ticks();
    endtask

    task automatic wait_idle();
        while (pending_events.size() != 0 || s_tvalid || expected_stats.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_TICK_RATE) p_rate = val; else p_winlen = val;
    endtask

    initial begin
        int phase, n;
        predict_reset();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes and special cases
        push_event(ACT_FRAME_END, 64'd5);                 // end with no frame
        push_event(ACT_DRAW_END, 64'd5);                  // draw end not drawing
        push_event(ACT_DRAW_BEGIN, 64'd100);              // opens a frame
        push_event(ACT_DRAW_BEGIN, 64'd200);              // moves draw start
        push_event(ACT_FRAME_END, 64'd300000);            // closes draw first
        push_event(ACT_FRAME_BEGIN, 64'd0);
        push_event(ACT_FRAME_BEGIN, 64'd10);              // restart
        push_event(ACT_FRAME_END, 64'd10);                // zero length
        push_event(3'd5, '1);
        push_event(3'd6, 64'd0);
        push_event(3'd7, '1);
        push_event(ACT_FRAME_BEGIN, 64'hFFFF_FFFF_FFFF_FFF0);
        push_event(ACT_DRAW_BEGIN, 64'hFFFF_FFFF_FFFF_FFF8);
        push_event(ACT_DRAW_END, 64'd400000);             // wrapping
        push_event(ACT_FRAME_END, 64'd350000);            // frame below draw
        push_event(ACT_FRAME_BEGIN, 64'd0);
        push_event(ACT_FRAME_END, '1);                    // saturating frame
        push_event(ACT_WIN_RESET, '1);
        drive_on = 1;
        wait_idle();

        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin write_reg(REG_TICK_RATE, 32'd0); write_reg(REG_WINDOW_LEN, 32'd1); end
                1: begin write_reg(REG_TICK_RATE, '1); write_reg(REG_WINDOW_LEN, '1); end
                2: begin write_reg(REG_TICK_RATE, 32'd1); write_reg(REG_WINDOW_LEN, 32'd0); end
                3: begin
                    write_reg(REG_TICK_RATE, 32'd3);
                    write_reg(REG_WINDOW_LEN, 32'd20000);
                end
                4: begin
                    write_reg(REG_TICK_RATE, $urandom_range(1000, 100000));
                    write_reg(REG_WINDOW_LEN, $urandom_range(1, 5000000));
                end
                default: begin
                    write_reg(REG_TICK_RATE, TICK_RATE_RESET);
                    write_reg(REG_WINDOW_LEN, 32'd100000);
                end
            endcase
            if (phase == 0) begin
                push_event(ACT_FRAME_BEGIN, 64'd0);
                push_event(ACT_FRAME_END, 64'd1000);      // measurement off
            end
            n = 0;
            while (n < 150) begin
                if ($urandom_range(0, 9) < 8) begin
                    push_frame();
                    n += 3;
                end else begin
                    push_noise();
                    n++;
                end
            end
            wait_idle();
        end

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
